>>> design/cms_pkg.sv
// shared types and constants for the can multiframe segmenter
// no dependencies; imported by cms_assemble, cms_out_reg and the top level
package cms_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int MAX_FRAMES  = 30;

    // identifier layout
    localparam int PRIO_SHIFT  = 24;
    localparam int ADDR_SHIFT  = 20;
    localparam int GROUP_SHIFT = 16;
    localparam int CMD_SHIFT   = 12;
    localparam int COUNT_SHIFT = 6;

    localparam int ID_W    = 29;
    localparam int FLEN_W  = 4;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIORITY = 2'd0,
        REG_SOURCE   = 2'd1,
        REG_GROUP    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [4:0] priority_cfg;
        logic [3:0] source_address;
        logic [3:0] group_number;
    } id_cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [FLEN_W-1:0] frame_length;
        logic [WORD_W-1:0] data_low;
        logic [WORD_W-1:0] data_high;
        logic              last_frame;
    } frame_t;

endpackage

>>> design/cms_assemble.sv
// message state and frame assembly: one payload byte per accepted request
// depends on cms_pkg
module cms_assemble (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            take,
    input  logic [7:0]      data_byte,
    input  logic [7:0]      message_length,
    input  logic [3:0]      command_code,
    input  cms_pkg::id_cfg_t id_cfg,
    output logic            emit,
    output cms_pkg::frame_t frame
);
    import cms_pkg::*;

    localparam int       CAP   = MAX_FRAMES * FRAME_BYTES;
    localparam logic [8:0] CAP9 = (CAP > 255) ? 9'd256 : 9'(CAP);

    logic [7:0]  bytes_taken_reg, bytes_taken_next;
    logic [4:0]  frame_number_reg, frame_number_next;
    logic [63:0] frame_bytes_reg, frame_bytes_next;
    logic [7:0]  held_length_reg, held_length_next;
    logic [3:0]  held_command_reg, held_command_next;

    logic        first;
    logic        drop;
    logic [7:0]  len_clamped;
    logic [7:0]  eff_len;
    logic [3:0]  eff_cmd;
    logic [4:0]  eff_fnum;
    logic [63:0] eff_bytes;
    logic [63:0] new_bytes;
    logic [2:0]  pos;
    logic [7:0]  taken_inc;
    logic        last;
    logic [8:0]  len_round;
    logic [5:0]  count;
    logic [5:0]  index;

    always_comb begin
        first       = (bytes_taken_reg == 8'd0);
        drop        = first && (message_length == 8'd0);
        len_clamped = ({1'b0, message_length} > CAP9) ? CAP9[7:0] : message_length;
        eff_len     = first ? len_clamped : held_length_reg;
        eff_cmd     = first ? command_code : held_command_reg;
        eff_fnum    = first ? 5'd0 : frame_number_reg;
        eff_bytes   = first ? 64'd0 : frame_bytes_reg;
        pos         = bytes_taken_reg[2:0];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            new_bytes[i*8 +: 8] = eff_bytes[i*8 +: 8] | ((pos == 3'(i)) ? data_byte : 8'd0);
        end
        taken_inc = bytes_taken_reg + 8'd1;
        last      = (taken_inc >= eff_len);
        emit      = !drop && (last || (taken_inc[2:0] == 3'd0));
        len_round = {1'b0, eff_len} + 9'd7;
        count     = len_round[8:3];
        index     = {1'b0, eff_fnum} + 6'd1;

        frame.frame_id     = {id_cfg.priority_cfg, id_cfg.source_address,
                              id_cfg.group_number, eff_cmd, count, index};
        frame.frame_length = {1'b0, pos} + 4'd1;
        frame.data_low     = new_bytes[31:0];
        frame.data_high    = new_bytes[63:32];
        frame.last_frame   = last;
    end

    always_comb begin
        bytes_taken_next  = bytes_taken_reg;
        frame_number_next = frame_number_reg;
        frame_bytes_next  = frame_bytes_reg;
        held_length_next  = held_length_reg;
        held_command_next = held_command_reg;
        if (take && !drop) begin
            held_length_next  = eff_len;
            held_command_next = eff_cmd;
            if (emit) begin
                frame_bytes_next = 64'd0;
                if (last) begin
                    bytes_taken_next  = 8'd0;
                    frame_number_next = 5'd0;
                end else begin
                    bytes_taken_next  = taken_inc;
                    frame_number_next = index[4:0];
                end
            end else begin
                bytes_taken_next  = taken_inc;
                frame_number_next = eff_fnum;
                frame_bytes_next  = new_bytes;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_taken_reg  <= 8'd0;
            frame_number_reg <= 5'd0;
            frame_bytes_reg  <= 64'd0;
            held_length_reg  <= 8'd0;
            held_command_reg <= 4'd0;
        end else begin
            bytes_taken_reg  <= bytes_taken_next;
            frame_number_reg <= frame_number_next;
            frame_bytes_reg  <= frame_bytes_next;
            held_length_reg  <= held_length_next;
            held_command_reg <= held_command_next;
        end
    end

endmodule

>>> design/cms_out_reg.sv
// result register holding one finished frame until the receiver takes it
// depends on cms_pkg
module cms_out_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  cms_pkg::frame_t frame_in,
    input  logic            m_ready,
    output logic            m_valid,
    output cms_pkg::frame_t frame_out
);
    import cms_pkg::*;

    logic   valid_reg, valid_next;
    frame_t frame_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_in;
        end
    end

    assign m_valid   = valid_reg;
    assign frame_out = frame_reg;

endmodule

>>> design/can_multiframe_segmenter_top.sv
// top level of the can multiframe segmenter: config registers, assembly, result register
// depends on cms_pkg, cms_assemble, cms_out_reg
//
// usage
//   s_ channel: one payload byte per request, in message order. message length
//     and command code are sampled only on the first byte of a message; a first
//     byte with length zero is dropped. lengths over 30 frames are clamped.
//   m_ channel: one can extended frame after every eighth byte and after the
//     final byte of a message, with 29-bit identifier, byte count, two
//     little-endian data words and a last-frame flag.
//   cfg channel: writes priority, source address and group; always ready.
//     write only while no message is in flight.
//   output: a frame is registered and on m_ in the cycle after the byte that completes it.
//   throughput: one byte per cycle; the result register lets a new byte in
//     while a finished frame waits, as long as it is taken that same cycle.
//   stall: with a frame waiting and m_ready low, s_ready drops until the
//     frame is taken.
//   reset: synchronous, active low; clears config registers, message state
//     and the output valid. no clearing pass.
module can_multiframe_segmenter_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_message_length,
    input  logic [3:0]  s_command_code,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [cms_pkg::ID_W-1:0]   m_frame_id,
    output logic [cms_pkg::FLEN_W-1:0] m_frame_length,
    output logic [cms_pkg::WORD_W-1:0] m_data_low,
    output logic [cms_pkg::WORD_W-1:0] m_data_high,
    output logic        m_last_frame,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cms_pkg::*;

    id_cfg_t id_cfg_reg;
    logic    take;
    logic    emit;
    frame_t  frame_new;
    frame_t  frame_held;

    // config writes, low bits of the data only
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PRIORITY: id_cfg_reg.priority_cfg   <= cfg_data[4:0];
                REG_SOURCE:   id_cfg_reg.source_address <= cfg_data[3:0];
                REG_GROUP:    id_cfg_reg.group_number   <= cfg_data[3:0];
                default:      id_cfg_reg <= id_cfg_reg;
            endcase
        end
    end

    // accept whenever the result register is free or being emptied
    assign s_ready = !m_valid || m_ready;
    assign take    = s_valid && s_ready;

    cms_assemble u_assemble (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .data_byte      (s_data_byte),
        .message_length (s_message_length),
        .command_code   (s_command_code),
        .id_cfg         (id_cfg_reg),
        .emit           (emit),
        .frame          (frame_new)
    );

    cms_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take && emit),
        .frame_in  (frame_new),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .frame_out (frame_held)
    );

    assign m_frame_id     = frame_held.frame_id;
    assign m_frame_length = frame_held.frame_length;
    assign m_data_low     = frame_held.data_low;
    assign m_data_high    = frame_held.data_high;
    assign m_last_frame   = frame_held.last_frame;

endmodule

>>> design/cms_checker.sv
// port-level checks for the can multiframe segmenter, bound to the top level
// depends on can_multiframe_segmenter_top port list
module cms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [28:0] m_frame_id,
    input logic [3:0]  m_frame_length,
    input logic [31:0] m_data_low,
    input logic [31:0] m_data_high,
    input logic        m_last_frame
);

    // no frame right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("frame valid after reset");

    // stalled frame holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_id)
            && $stable(m_data_low) && $stable(m_data_high)
            && $stable(m_frame_length) && $stable(m_last_frame))
        else $error("stalled frame changed");

    // only the last frame may be short
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_frame |-> m_frame_length == 4'd8)
        else $error("short frame not flagged last");

    // frame index within frame count, and equal to it on the last frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_id[5:0] != 6'd0 && m_frame_id[5:0] <= m_frame_id[11:6]
            && (!m_last_frame || m_frame_id[5:0] == m_frame_id[11:6]))
        else $error("frame index inconsistent with frame count");

endmodule

bind can_multiframe_segmenter_top cms_checker u_cms_checker (.*);
